/* hw/rtl/aesige_pkg.sv */
package aesige_pkg;

   // Cipher geometry.
   localparam int EXPANDED_WORDS = 60;
   localparam int BLOCK_BYTES    = 16;
   localparam int KEY_ADDR_W     = $clog2(EXPANDED_WORDS);
   localparam logic [3:0] NUM_ROUNDS = 4'd14;
   localparam logic [5:0] LAST_KEY_WORD = 6'(EXPANDED_WORDS - 1);
   localparam logic [5:0] LAST_SUB_BYTE = 6'(BLOCK_BYTES - 1);
   localparam logic [5:0] KEY_FETCH_END = 6'd4;

   // Configuration register indexes.
   localparam logic [2:0] REG_KEY_0 = 3'd0;
   localparam logic [2:0] REG_KEY_1 = 3'd1;
   localparam logic [2:0] REG_KEY_2 = 3'd2;
   localparam logic [2:0] REG_KEY_3 = 3'd3;
   localparam logic [2:0] REG_IV_0  = 3'd4;
   localparam logic [2:0] REG_IV_1  = 3'd5;
   localparam logic [2:0] REG_IV_2  = 3'd6;
   localparam logic [2:0] REG_IV_3  = 3'd7;

   // Direction codes.
   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEXP,
      ST_KEY,
      ST_ARK,
      ST_SUB,
      ST_MIX,
      ST_DONE
   } state_type;

   localparam logic [7:0] RCON [8] = '{8'h00, 8'h01, 8'h02, 8'h04,
                                       8'h08, 8'h10, 8'h20, 8'h40};

   localparam logic [7:0] FWD_SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

   function automatic logic [7:0] sub_byte(input logic [7:0] b, input logic inv);
      return inv ? INV_SBOX[b] : FWD_SBOX[b];
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of the block sits in bits [127-8i -: 8].
   function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
      logic [127:0] t;
      int src;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = inv ? 4 * ((c + 3 * r) & 3) + r : 4 * ((c + r) & 3) + r;
            t[127 - 8 * (4 * c + r) -: 8] = s[127 - 8 * src -: 8];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_cols(input logic [127:0] s, input logic inv);
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3;
      logic [7:0] x0, x1, x2, x3;
      logic [7:0] y0, y1, y2, y3;
      logic [7:0] z0, z1, z2, z3;
      logic [7:0] m0, m1, m2, m3;
      logic [7:0] b0, b1, b2, b3;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32 * c -: 8];
         a1 = s[119 - 32 * c -: 8];
         a2 = s[111 - 32 * c -: 8];
         a3 = s[103 - 32 * c -: 8];
         x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
         y0 = xtime(x0); y1 = xtime(x1); y2 = xtime(x2); y3 = xtime(x3);
         z0 = xtime(y0); z1 = xtime(y1); z2 = xtime(y2); z3 = xtime(y3);
         if (inv) begin
            // Multiples 14, 11, 13 and 9 built from the xtime chain.
            m0 = z0 ^ y0 ^ x0;      m1 = z1 ^ x1 ^ a1;
            m2 = z2 ^ y2 ^ a2;      m3 = z3 ^ a3;
            b0 = m0 ^ m1 ^ m2 ^ m3;
            b1 = (z0 ^ a0) ^ (z1 ^ y1 ^ x1) ^ (z2 ^ x2 ^ a2) ^ (z3 ^ y3 ^ a3);
            b2 = (z0 ^ y0 ^ a0) ^ (z1 ^ a1) ^ (z2 ^ y2 ^ x2) ^ (z3 ^ x3 ^ a3);
            b3 = (z0 ^ x0 ^ a0) ^ (z1 ^ y1 ^ a1) ^ (z2 ^ a2) ^ (z3 ^ y3 ^ x3);
         end else begin
            m0 = '0; m1 = '0; m2 = '0; m3 = '0;
            b0 = x0 ^ (x1 ^ a1) ^ a2 ^ a3;
            b1 = a0 ^ x1 ^ (x2 ^ a2) ^ a3;
            b2 = a0 ^ a1 ^ x2 ^ (x3 ^ a3);
            b3 = (x0 ^ a0) ^ a1 ^ a2 ^ x3;
         end
         t[127 - 32 * c -: 32] = {b0, b1, b2, b3} ^ {m0 & 8'h00, m1 & 8'h00, m2 & 8'h00, m3 & 8'h00};
      end
      return t;
   endfunction

endpackage

/* hw/rtl/aesige_ram.sv */
module aesige_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 60,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* hw/rtl/aes256_ige_block_cipher.sv */
// The key schedule is rebuilt when the item is the first of a message. A new item is
// taken only in the idle state, once the last result has been loaded for output.
// Each of the 14 rounds fetches its round key from the key RAM, passes the state through
// the single byte-wide S-box one byte at a time and, but in the last round, mixes columns.
// Reset is synchronous and active high; it clears control, chaining and key registers.
module aes256_ige_block_cipher (
   input  logic         clock,
   input  logic         reset,
   // Input channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // block_high [63:0], block_low [127:64]
   input  logic [1:0]   req_tuser,  // op [0], first [1]
   // Result channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,  // result_high [63:0], result_low [127:64]
   // Register write channel.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);

   localparam int AW = aesige_pkg::KEY_ADDR_W;

   aesige_pkg::state_type state_ff, state_in;

   logic [63:0]  cfg_ff [8];
   logic [127:0] po_ff, pi_ff, blk_ff, st_ff, rk_ff, rsp_data_ff;
   logic [255:0] kw_ff;
   logic [5:0]   cnt_ff;
   logic [3:0]   rnd_ff;
   logic         op_ff, rsp_valid_ff;

   logic         req_fire, out_free;
   logic [127:0] iv_lo, iv_hi, po_sel, pi_sel, blk_in, mixed;
   logic [6:0]   kidx;
   logic [31:0]  kt, knew;
   logic [3:0]   key_round;
   logic         ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [31:0]  ram_rdata;

   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff[63:0], rsp_data_ff[127:64]};

   // Chaining seeds from the IV halves.
   assign iv_lo  = {cfg_ff[aesige_pkg::REG_IV_0], cfg_ff[aesige_pkg::REG_IV_1]};
   assign iv_hi  = {cfg_ff[aesige_pkg::REG_IV_2], cfg_ff[aesige_pkg::REG_IV_3]};
   assign blk_in = {req_tdata[63:0], req_tdata[127:64]};

   always_comb begin
      if (req_tuser[1]) begin
         po_sel = (req_tuser[0] == aesige_pkg::OP_DECRYPT) ? iv_hi : iv_lo;
         pi_sel = (req_tuser[0] == aesige_pkg::OP_DECRYPT) ? iv_lo : iv_hi;
      end else begin
         po_sel = po_ff;
         pi_sel = pi_ff;
      end
   end

   // Next key schedule word from the eight-word window.
   always_comb begin
      kidx = 7'(cnt_ff) + 7'd8;
      kt   = kw_ff[31:0];
      if (kidx[2:0] == 3'd0) begin
         kt = aesige_pkg::sub_word({kt[23:0], kt[31:24]}) ^
              {aesige_pkg::RCON[kidx[5:3]], 24'h0};
      end else if (kidx[2:0] == 3'd4) begin
         kt = aesige_pkg::sub_word(kt);
      end
      knew = kw_ff[255:224] ^ kt;
   end

   // Round transform applied after the byte-serial substitution.
   always_comb begin
      logic [127:0] t;
      t = aesige_pkg::shift_rows(st_ff, op_ff);
      if (op_ff == aesige_pkg::OP_DECRYPT) begin
         t = t ^ rk_ff;
         if (rnd_ff != aesige_pkg::NUM_ROUNDS) t = aesige_pkg::mix_cols(t, 1'b1);
      end else begin
         if (rnd_ff != aesige_pkg::NUM_ROUNDS) t = aesige_pkg::mix_cols(t, 1'b0);
         t = t ^ rk_ff;
      end
      mixed = t;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         aesige_pkg::ST_IDLE: begin
            if (req_fire) state_in = req_tuser[1] ? aesige_pkg::ST_KEXP : aesige_pkg::ST_KEY;
         end
         aesige_pkg::ST_KEXP: begin
            if (cnt_ff == aesige_pkg::LAST_KEY_WORD) state_in = aesige_pkg::ST_KEY;
         end
         aesige_pkg::ST_KEY: begin
            if (cnt_ff == aesige_pkg::KEY_FETCH_END) begin
               state_in = (rnd_ff == 4'd0) ? aesige_pkg::ST_ARK : aesige_pkg::ST_SUB;
            end
         end
         aesige_pkg::ST_ARK: state_in = aesige_pkg::ST_KEY;
         aesige_pkg::ST_SUB: begin
            if (cnt_ff == aesige_pkg::LAST_SUB_BYTE) state_in = aesige_pkg::ST_MIX;
         end
         aesige_pkg::ST_MIX: begin
            state_in = (rnd_ff == aesige_pkg::NUM_ROUNDS) ? aesige_pkg::ST_DONE
                                                          : aesige_pkg::ST_KEY;
         end
         aesige_pkg::ST_DONE: begin
            if (out_free) state_in = aesige_pkg::ST_IDLE;
         end
         default: state_in = aesige_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake and key RAM control.
   always_comb begin
      key_round  = (op_ff == aesige_pkg::OP_DECRYPT) ? aesige_pkg::NUM_ROUNDS - rnd_ff : rnd_ff;
      req_tready = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = cnt_ff[AW-1:0];
      ram_raddr  = {key_round, 2'b00} + {4'b0000, cnt_ff[1:0]};
      unique case (state_ff)
         aesige_pkg::ST_IDLE: req_tready = 1'b1;
         aesige_pkg::ST_KEXP: ram_we = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aesige_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         po_ff        <= '0;
         pi_ff        <= '0;
         for (int i = 0; i < 8; i++) cfg_ff[i] <= '0;
      end else begin
         state_ff <= state_in;

         // Register writes.
         if (csr_valid && csr_ready) cfg_ff[csr_index] <= csr_data;

         // Result register drains on a transfer; the done state loads it itself.
         if (rsp_valid_ff && rsp_tready && (state_ff != aesige_pkg::ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            aesige_pkg::ST_IDLE: begin
               cnt_ff <= '0;
               rnd_ff <= '0;
               if (req_fire) begin
                  op_ff  <= req_tuser[0];
                  blk_ff <= blk_in;
                  po_ff  <= po_sel;
                  pi_ff  <= pi_sel;
                  st_ff  <= blk_in ^ po_sel;
                  kw_ff  <= {cfg_ff[aesige_pkg::REG_KEY_0], cfg_ff[aesige_pkg::REG_KEY_1],
                             cfg_ff[aesige_pkg::REG_KEY_2], cfg_ff[aesige_pkg::REG_KEY_3]};
               end
            end
            aesige_pkg::ST_KEXP: begin
               kw_ff  <= {kw_ff[223:0], knew};
               cnt_ff <= (cnt_ff == aesige_pkg::LAST_KEY_WORD) ? 6'd0 : cnt_ff + 6'd1;
            end
            aesige_pkg::ST_KEY: begin
               if (cnt_ff != 6'd0) rk_ff <= {rk_ff[95:0], ram_rdata};
               cnt_ff <= (cnt_ff == aesige_pkg::KEY_FETCH_END) ? 6'd0 : cnt_ff + 6'd1;
            end
            aesige_pkg::ST_ARK: begin
               st_ff  <= st_ff ^ rk_ff;
               rnd_ff <= 4'd1;
            end
            aesige_pkg::ST_SUB: begin
               st_ff  <= {st_ff[119:0], aesige_pkg::sub_byte(st_ff[127:120], op_ff)};
               cnt_ff <= (cnt_ff == aesige_pkg::LAST_SUB_BYTE) ? 6'd0 : cnt_ff + 6'd1;
            end
            aesige_pkg::ST_MIX: begin
               st_ff <= mixed;
               if (rnd_ff != aesige_pkg::NUM_ROUNDS) rnd_ff <= rnd_ff + 4'd1;
            end
            aesige_pkg::ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= st_ff ^ pi_ff;
                  po_ff        <= st_ff ^ pi_ff;
                  pi_ff        <= blk_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Expanded key schedule.
   aesige_ram #(
      .WIDTH (32),
      .DEPTH (aesige_pkg::EXPANDED_WORDS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (kw_ff[255:224]),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

/* hw/rtl/aesige_checker.sv */
module aesige_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // The block is busy right after taking an item.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready high right after an input transfer");

   // A result never appears in the cycle after an input transfer.
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared too early");

   // Reset empties the result register and frees the input.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("reset did not clear the result channel");

endmodule

bind aes256_ige_block_cipher aesige_checker u_chk (.*);
